FILE: rtl/ntt_pkg.sv
// NAPT translation table: shared constants, codes and link types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ntt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam logic [15:0] PORT_TOP  = 16'd65535;
   localparam logic [15:0] PORT_WRAP = 16'd49152;

   typedef enum logic [2:0] {
      ST_UNCHANGED = 3'd0,
      ST_OUT_EXIST = 3'd1,
      ST_OUT_NEW   = 3'd2,
      ST_INBOUND   = 3'd3,
      ST_NO_MAP    = 3'd4,
      ST_FULL      = 3'd5,
      ST_LOADED    = 3'd6,
      ST_LOAD_FULL = 3'd7
   } status_type;

   typedef enum logic {
      CMD_TRANSLATE = 1'b0,
      CMD_LOAD      = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SEARCH
   } state_type;

   typedef struct packed {
      logic [31:0] lan_address;
      logic [15:0] lan_portnum;
      logic [15:0] wan_portnum;
   } entry_type;

   // Search key broadcast to all cells
   typedef struct packed {
      logic        inbound;
      logic [31:0] ip;
      logic [15:0] port;
   } key_type;

   // Entry write broadcast to all cells
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        entry;
   } write_type;

   // What one cell hands to its neighbor: first hit so far and its entry
   typedef struct packed {
      logic      hit;
      entry_type entry;
   } link_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] src_ip;
      logic [15:0] src_portnum;
      logic [31:0] dst_ip;
      logic [15:0] dst_port;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/ntt_cell.sv
// NAPT translation table: one cell of the mapping chain, holding one entry.
// Depends on ntt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntt_cell
   import ntt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [IDX_W-1:0]   cell_index,
   input  wire logic [COUNT_W-1:0] entry_count,
   input  wire key_type            key,
   input  wire write_type          wr,
   input  wire link_type           prev_link,
   output link_type                next_link
);

   entry_type entry_ff;
   link_type  chain_ff;
   link_type  chain_in;
   logic      live;
   logic      match;

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == cell_index)) begin
         entry_ff <= wr.entry;
      end
   end

   assign live  = COUNT_W'(cell_index) < entry_count;
   assign match = key.inbound ? (entry_ff.wan_portnum == key.port)
                              : ((entry_ff.lan_address == key.ip) &&
                                 (entry_ff.lan_portnum == key.port));

   // Keep an earlier hit; otherwise offer this entry
   always_comb begin
      if (prev_link.hit) begin
         chain_in = prev_link;
      end else begin
         chain_in.hit   = live && match;
         chain_in.entry = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      chain_ff <= chain_in;
   end

   assign next_link = chain_ff;

endmodule

`default_nettype wire

FILE: rtl/ntt_ctrl.sv
// NAPT translation table: sequencer, request and result registers, WAN
// address, entry count and port counter. Depends on ntt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntt_ctrl
   import ntt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_command,
   input  wire logic [31:0]        req_src_ip,
   input  wire logic [15:0]        req_src_port,
   input  wire logic [31:0]        req_dst_ip,
   input  wire logic [15:0]        req_dst_port,
   input  wire logic               req_dst_is_lan_host,
   input  wire logic [15:0]        req_static_wan_port,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [31:0]        csr_data,
   input  wire link_type           chain_end,
   output key_type                 key,
   output write_type               wr,
   output logic [COUNT_W-1:0]      entry_count,
   output logic                    rsp_valid,
   output rsp_type                 rsp
);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        port_ff, port_in;
   logic [31:0]        wan_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   command_type        cmd_ff, cmd_in;
   logic [31:0]        sip_ff, sip_in;
   logic [15:0]        sport_ff, sport_in;
   logic [31:0]        dip_ff, dip_in;
   logic [15:0]        dport_ff, dport_in;
   logic               lan_host_ff, lan_host_in;
   logic [15:0]        swan_ff, swan_in;

   logic               inbound;
   logic               full;
   logic [15:0]        alloc_port;

   assign inbound    = (dip_ff == wan_ff);
   assign full       = (count_ff >= COUNT_W'(TABLE_DEPTH));
   assign alloc_port = (port_ff < PORT_TOP) ? (port_ff + 16'd1) : PORT_WRAP;

   assign key.inbound = inbound;
   assign key.ip      = sip_ff;
   assign key.port    = inbound ? dport_ff : sport_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      port_in      = port_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd_in       = cmd_ff;
      sip_in       = sip_ff;
      sport_in     = sport_ff;
      dip_in       = dip_ff;
      dport_in     = dport_ff;
      lan_host_in  = lan_host_ff;
      swan_in      = swan_ff;
      wr.en        = 1'b0;
      wr.idx       = count_ff[IDX_W-1:0];
      wr.entry     = '{lan_address: sip_ff, lan_portnum: sport_ff, wan_portnum: swan_ff};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in      = command_type'(req_command);
               sip_in      = req_src_ip;
               sport_in    = req_src_port;
               dip_in      = req_dst_ip;
               dport_in    = req_dst_port;
               lan_host_in = req_dst_is_lan_host;
               swan_in     = req_static_wan_port;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cnt_in = '0;
            if (cmd_ff == CMD_LOAD) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (full) begin
                  rsp_in = '{ST_LOAD_FULL, 32'd0, 16'd0, 32'd0, 16'd0};
               end else begin
                  wr.en    = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
                  rsp_in   = '{ST_LOADED, 32'd0, 16'd0, 32'd0, 16'd0};
               end
            end else if (!inbound && lan_host_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               rsp_in       = '{ST_UNCHANGED, sip_ff, sport_ff, dip_ff, dport_ff};
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (inbound) begin
                  if (chain_end.hit) begin
                     rsp_in = '{ST_INBOUND, sip_ff, sport_ff,
                                chain_end.entry.lan_address,
                                chain_end.entry.lan_portnum};
                  end else begin
                     rsp_in = '{ST_NO_MAP, 32'd0, 16'd0, 32'd0, 16'd0};
                  end
               end else if (chain_end.hit) begin
                  rsp_in = '{ST_OUT_EXIST, wan_ff, chain_end.entry.wan_portnum,
                             dip_ff, dport_ff};
               end else if (full) begin
                  rsp_in = '{ST_FULL, 32'd0, 16'd0, 32'd0, 16'd0};
               end else begin
                  wr.en                = 1'b1;
                  wr.entry.wan_portnum = alloc_port;
                  count_in             = count_ff + COUNT_W'(1);
                  port_in              = alloc_port;
                  rsp_in               = '{ST_OUT_NEW, wan_ff, alloc_port, dip_ff, dport_ff};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         port_ff      <= '0;
         wan_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         port_ff      <= port_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            wan_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
      cmd_ff      <= cmd_in;
      sip_ff      <= sip_in;
      sport_ff    <= sport_in;
      dip_ff      <= dip_in;
      dport_ff    <= dport_in;
      lan_host_ff <= lan_host_in;
      swan_ff     <= swan_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign csr_ready   = (state_ff == S_IDLE);
   assign entry_count = count_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp         = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/napt_translation_table_top.sv
// NAPT translation table, top level: sequencer plus a chain of table cells.
// Depends on ntt_pkg, ntt_ctrl and ntt_cell.
//
//   Channel    Ports                          Transaction taken when
//   --------   ----------------------------   ---------------------------------
//   request    start, busy, req_*             start high and busy low
//   result     rsp_valid, rsp_*               rsp_valid high (one-cycle strobe)
//   config     csr_valid, csr_ready, csr_data csr_valid and csr_ready high
//
// A load command, or a packet to a LAN host that is not addressed to the
// WAN address, gives its result from the decide state. Any packet that
// needs a table lookup gives it from the search state, once the first-hit
// link has rippled through the chain of cells, one cell per cycle.
// busy drops in the cycle the result strobe shows, so the next transaction
// can be taken in that same cycle. The receiver cannot stall results.
// Reset is synchronous and clears the entry count, port counter, WAN address
// and sequencer; table contents are not cleared and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module napt_translation_table_top
   import ntt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_command,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [15:0] req_src_port,
   input  wire logic [31:0] req_dst_ip,
   input  wire logic [15:0] req_dst_port,
   input  wire logic        req_dst_is_lan_host,
   input  wire logic [15:0] req_static_wan_port,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_out_src_ip,
   output logic [15:0]      rsp_out_src_port,
   output logic [31:0]      rsp_out_dst_ip,
   output logic [15:0]      rsp_out_dst_port,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   key_type            key;
   write_type          wr;
   logic [COUNT_W-1:0] entry_count;
   rsp_type            rsp;
   link_type           links [TABLE_DEPTH+1];

   // Sequencer: latch and classify the transaction, load or pass it through,
   // or wait out the chain and allocate, drop or translate; strobe the result.
   ntt_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_src_ip          (req_src_ip),
      .req_src_port        (req_src_port),
      .req_dst_ip          (req_dst_ip),
      .req_dst_port        (req_dst_port),
      .req_dst_is_lan_host (req_dst_is_lan_host),
      .req_static_wan_port (req_static_wan_port),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data),
      .chain_end           (links[TABLE_DEPTH]),
      .key                 (key),
      .wr                  (wr),
      .entry_count         (entry_count),
      .rsp_valid           (rsp_valid),
      .rsp                 (rsp)
   );

   // Head of the chain: no hit yet
   assign links[0] = '0;

   // One cell per table entry, in insertion order. Each cell compares its
   // entry to the broadcast key and passes the earliest hit onward, so the
   // chain end holds the first match in insertion order.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ntt_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .entry_count (entry_count),
         .key         (key),
         .wr          (wr),
         .prev_link   (links[i]),
         .next_link   (links[i+1])
      );
   end

   // Drive the result ports from the registered result
   assign rsp_status       = rsp.status;
   assign rsp_out_src_ip   = rsp.src_ip;
   assign rsp_out_src_port = rsp.src_portnum;
   assign rsp_out_dst_ip   = rsp.dst_ip;
   assign rsp_out_dst_port = rsp.dst_port;

endmodule

`default_nettype wire

FILE: rtl/ntt_checker.sv
// NAPT translation table: port-level checker and its bind to the top level.
// Depends on ntt_pkg and napt_translation_table_top.
`timescale 1ns / 1ps
`default_nettype none

module ntt_checker
   import ntt_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_out_src_ip,
   input wire logic [15:0] rsp_out_src_port,
   input wire logic [31:0] rsp_out_dst_ip,
   input wire logic [15:0] rsp_out_dst_port
);

   // An accepted transaction holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // No result in the cycle right after acceptance
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result strobed too early");

   // A result ends the busy period
   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe not at end of busy period");

   // One strobe per transaction
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // Drops and load commands carry all-zero addresses and ports
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == ST_NO_MAP) || (rsp_status == ST_FULL) ||
                     (rsp_status == ST_LOADED) || (rsp_status == ST_LOAD_FULL)))
      |-> ((rsp_out_src_ip == 32'd0) && (rsp_out_src_port == 16'd0) &&
           (rsp_out_dst_ip == 32'd0) && (rsp_out_dst_port == 16'd0)))
      else $error("dropped or load result has nonzero fields");

endmodule

bind napt_translation_table_top ntt_checker u_ntt_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_out_src_ip   (rsp_out_src_ip),
   .rsp_out_src_port (rsp_out_src_port),
   .rsp_out_dst_ip   (rsp_out_dst_ip),
   .rsp_out_dst_port (rsp_out_dst_port)
);

`default_nettype wire
